@@ hw/rtl/gvfr_pkg.sv @@
// gvfr_pkg: shared types, constants and command/status structs
// for the gesture velocity frame rate governor; no dependencies

package gvfr_pkg;

  localparam int SpeedBits = 24;
  localparam int EntriesPerTable = 3;
  localparam int CfgIdxW = 3;
  localparam int CfgDataW = 59;

  localparam logic [CfgIdxW-1:0] RegScale = 3'd0;
  localparam logic [CfgIdxW-1:0] RegMode = 3'd1;
  localparam logic [CfgIdxW-1:0] RegScroll0 = 3'd2;
  localparam logic [CfgIdxW-1:0] RegScroll1 = 3'd3;
  localparam logic [CfgIdxW-1:0] RegScroll2 = 3'd4;
  localparam logic [CfgIdxW-1:0] RegFling0 = 3'd5;
  localparam logic [CfgIdxW-1:0] RegFling1 = 3'd6;
  localparam logic [CfgIdxW-1:0] RegFling2 = 3'd7;

  localparam logic [2:0] OpStartSlide = 3'd0;
  localparam logic [2:0] OpStopSlide = 3'd1;
  localparam logic [2:0] OpStartFling = 3'd2;
  localparam logic [2:0] OpStopFling = 3'd3;
  localparam logic [2:0] OpScroll = 3'd4;
  localparam logic [2:0] OpFlingUpd = 3'd5;

  localparam logic [1:0] StratTable = 2'd1;
  localparam logic [1:0] StratAps = 2'd2;

  localparam logic [1:0] NoticeNone = 2'd0;
  localparam logic [1:0] NoticeStop = 2'd1;
  localparam logic [1:0] NoticeStart = 2'd2;

  localparam logic [8:0] RateDefault = 9'd120;
  localparam logic [8:0] RateCap = 9'd90;
  localparam logic [19:0] UsecPerSec = 20'd1000000;

  typedef enum logic [3:0] {
    StIdle, StSqrt, StMul, StDiv, StScale, StPick, StOut
  } gvfr_state_e;

  typedef struct packed {
    logic load;      // capture inputs, start magnitude
    logic sqrt_step;
    logic mul_us;
    logic div_step;
    logic scale;
    logic sat;       // force max speed
    logic pick;
  } gvfr_cmd_t;

  typedef struct packed {
    logic sqrt_done;
    logic div_done;
    logic dt_zero;
  } gvfr_sts_t;

endpackage

@@ hw/rtl/gvfr_ctrl.sv @@
// gvfr_ctrl: controller fsm, gesture state and handshake
// depends on gvfr_pkg

module gvfr_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [2:0]            op_i,
  input  logic [2:0]            mode_i,
  input  gvfr_pkg::gvfr_sts_t   sts_i,
  input  logic [8:0]            rate_i,
  output gvfr_pkg::gvfr_cmd_t   cmd_o,
  output logic                  clr_time_o,
  output logic                  set_time_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic                  status_o,
  output logic [8:0]            frame_rate_o,
  output logic [1:0]            scene_notice_o
);

  gvfr_pkg::gvfr_state_e state_q, state_d;
  logic sliding_q, sliding_d, flinging_q, flinging_d;
  logic [8:0] cur_q, cur_d;
  logic [2:0] op_q, op_d;
  logic ovalid_q, ovalid_d, st_q, st_d;
  logic [8:0] fr_q, fr_d;
  logic [1:0] sn_q, sn_d;
  logic inited, aps, acc, upd;

  assign inited = mode_i[1:0] == gvfr_pkg::StratTable || mode_i[1:0] == gvfr_pkg::StratAps;
  assign aps = mode_i[1:0] == gvfr_pkg::StratAps;
  assign in_ready_o = state_q == gvfr_pkg::StIdle && !ovalid_q;
  assign acc = in_valid_i && in_ready_o;
  assign upd = sliding_q && !aps &&
               ((op_i == gvfr_pkg::OpScroll && !flinging_q) ||
                (op_i == gvfr_pkg::OpFlingUpd && flinging_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= gvfr_pkg::StIdle;
      sliding_q <= 1'b0;
      flinging_q <= 1'b0;
      cur_q <= '0;
      op_q <= '0;
      ovalid_q <= 1'b0;
      st_q <= 1'b1;
      fr_q <= '0;
      sn_q <= '0;
    end else begin
      state_q <= state_d;
      sliding_q <= sliding_d;
      flinging_q <= flinging_d;
      cur_q <= cur_d;
      op_q <= op_d;
      ovalid_q <= ovalid_d;
      st_q <= st_d;
      fr_q <= fr_d;
      sn_q <= sn_d;
    end
  end

  always_comb begin
    state_d = state_q;
    sliding_d = sliding_q;
    flinging_d = flinging_q;
    cur_d = cur_q;
    op_d = op_q;
    ovalid_d = ovalid_q && !out_ready_i;
    st_d = st_q;
    fr_d = fr_q;
    sn_d = sn_q;
    cmd_o = '0;
    clr_time_o = 1'b0;
    set_time_o = 1'b0;
    unique case (state_q)
      gvfr_pkg::StIdle: begin
        if (acc) begin
          op_d = op_i;
          st_d = 1'b1;
          fr_d = '0;
          sn_d = gvfr_pkg::NoticeNone;
          ovalid_d = 1'b1;
          unique case (op_i)
            gvfr_pkg::OpStartSlide: begin
              if (inited && !sliding_q) begin
                set_time_o = 1'b1;
                sliding_d = 1'b1;
                flinging_d = 1'b0;
                st_d = 1'b0;
              end
            end
            gvfr_pkg::OpStopSlide: begin
              if (inited && sliding_q && !flinging_q) begin
                clr_time_o = 1'b1;
                sliding_d = 1'b0;
                cur_d = '0;
                st_d = 1'b0;
              end
            end
            gvfr_pkg::OpStartFling: begin
              if (inited && sliding_q) begin
                flinging_d = 1'b1;
                st_d = 1'b0;
                if (aps) sn_d = gvfr_pkg::NoticeStart;
              end
            end
            gvfr_pkg::OpStopFling: begin
              if (inited && sliding_q && flinging_q) begin
                clr_time_o = 1'b1;
                sliding_d = 1'b0;
                flinging_d = 1'b0;
                cur_d = '0;
                st_d = 1'b0;
                if (aps) sn_d = gvfr_pkg::NoticeStop;
              end
            end
            gvfr_pkg::OpScroll, gvfr_pkg::OpFlingUpd: begin
              if (upd) begin
                cmd_o.load = 1'b1;
                ovalid_d = 1'b0;
                state_d = gvfr_pkg::StSqrt;
              end
            end
            default: ;
          endcase
        end
      end
      gvfr_pkg::StSqrt: begin
        cmd_o.sqrt_step = 1'b1;
        if (sts_i.sqrt_done) begin
          state_d = op_q == gvfr_pkg::OpScroll ? gvfr_pkg::StMul : gvfr_pkg::StScale;
        end
      end
      gvfr_pkg::StMul: begin
        cmd_o.mul_us = 1'b1;
        set_time_o = 1'b1;
        state_d = gvfr_pkg::StDiv;
      end
      gvfr_pkg::StDiv: begin
        if (sts_i.dt_zero) begin
          cmd_o.sat = 1'b1;
          state_d = gvfr_pkg::StPick;
        end else begin
          cmd_o.div_step = 1'b1;
          if (sts_i.div_done) state_d = gvfr_pkg::StScale;
        end
      end
      gvfr_pkg::StScale: begin
        cmd_o.scale = 1'b1;
        state_d = gvfr_pkg::StPick;
      end
      gvfr_pkg::StPick: begin
        cmd_o.pick = 1'b1;
        state_d = gvfr_pkg::StOut;
      end
      gvfr_pkg::StOut: begin
        if (rate_i != cur_q) begin
          cur_d = rate_i;
          st_d = 1'b0;
          fr_d = rate_i;
        end
        ovalid_d = 1'b1;
        state_d = gvfr_pkg::StIdle;
      end
      default: state_d = gvfr_pkg::StIdle;
    endcase
  end

  assign out_valid_o = ovalid_q;
  assign status_o = st_q;
  assign frame_rate_o = fr_q;
  assign scene_notice_o = sn_q;

endmodule

@@ hw/rtl/gvfr_dpath.sv @@
// gvfr_dpath: magnitude root, divide, scaling and range lookup
// depends on gvfr_pkg

module gvfr_dpath (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  gvfr_pkg::gvfr_cmd_t   cmd_i,
  input  logic                  clr_time_i,
  input  logic                  set_time_i,
  input  logic [2:0]            op_i,
  input  logic signed [31:0]    motion_x_i,
  input  logic signed [31:0]    motion_y_i,
  input  logic [62:0]           timestamp_us_i,
  input  logic [23:0]           scale_i,
  input  logic [2:0]            mode_i,
  input  logic [58:0]           scroll_i [3],
  input  logic [58:0]           fling_i [3],
  output gvfr_pkg::gvfr_sts_t   sts_o,
  output logic [8:0]            rate_o
);

  localparam int SPEEDW = gvfr_pkg::SpeedBits;
  logic [62:0] last_q, ts_q;
  logic        fl_q;
  logic [63:0] rem_q, sq_r_q, sqbit_q;
  logic [31:0] ax, ay;
  logic [63:0] xx, yy;
  logic [62:0] dt;
  logic [63:0] num_q, quo_q;
  logic [62:0] dvr_q;
  logic [63:0] drem_q;
  logic [6:0]  dcnt_q;
  logic [63:0] amt_q;
  logic [SPEEDW-1:0] speed_q;
  logic [8:0]  rate_q;
  logic [63:0] trial;
  logic [64:0] dsh;
  logic [55:0] plo;
  logic [55:0] phi;
  logic [63:0] mmv;
  logic [8:0]  pk;
  logic [58:0] e;

  assign ax = motion_x_i[31] ? 32'(-motion_x_i) : motion_x_i;
  assign ay = motion_y_i[31] ? 32'(-motion_y_i) : motion_y_i;
  assign xx = 64'(ax) * 64'(ax);
  assign yy = 64'(ay) * 64'(ay);
  assign dt = ts_q >= last_q ? ts_q - last_q : last_q - ts_q;
  assign trial = sq_r_q + sqbit_q;
  assign dsh = {drem_q, num_q[63]};

  assign sts_o.sqrt_done = sqbit_q == '0;
  assign sts_o.div_done = dcnt_q == 7'd1;
  assign sts_o.dt_zero = dvr_q == '0;

  assign plo = 56'(amt_q[31:0]) * 56'(scale_i);
  assign phi = 56'(amt_q[63:32]) * 56'(scale_i);
  assign mmv = (64'(phi) << 4) + 64'(plo >> 28);

  always_comb begin
    pk = gvfr_pkg::RateDefault;
    e = '0;
    for (int k = gvfr_pkg::EntriesPerTable - 1; k >= 0; k--) begin
      e = fl_q ? fling_i[k] : scroll_i[k];
      if (e[0] && 24'(speed_q) >= e[24:1] && (24'(speed_q) < e[48:25] || e[49])) begin
        pk = e[58:50];
      end
    end
    if (mode_i[2] && pk > gvfr_pkg::RateCap) pk = gvfr_pkg::RateCap;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q <= '0;
    end else if (clr_time_i) begin
      last_q <= '0;
    end else if (set_time_i) begin
      last_q <= cmd_i.mul_us ? ts_q : timestamp_us_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      ts_q <= timestamp_us_i;
      fl_q <= op_i == gvfr_pkg::OpFlingUpd;
      rem_q <= xx + yy;
      sq_r_q <= '0;
      sqbit_q <= 64'h4000_0000_0000_0000;
    end
    if (cmd_i.sqrt_step) begin
      if (sqbit_q != '0) begin
        if (sqbit_q > rem_q && sq_r_q == '0) begin
          sqbit_q <= sqbit_q >> 2;
        end else begin
          if (rem_q >= trial) begin
            rem_q <= rem_q - trial;
            sq_r_q <= (sq_r_q >> 1) + sqbit_q;
          end else begin
            sq_r_q <= sq_r_q >> 1;
          end
          sqbit_q <= sqbit_q >> 2;
        end
      end
      amt_q <= sq_r_q;
    end
    if (cmd_i.mul_us) begin
      num_q <= 64'(53'(sq_r_q[32:0]) * 53'(gvfr_pkg::UsecPerSec));
      dvr_q <= dt;
      drem_q <= '0;
      dcnt_q <= 7'd64;
    end
    if (cmd_i.div_step) begin
      num_q <= {num_q[62:0], 1'b0};
      if (dsh >= 65'(dvr_q)) begin
        drem_q <= 64'(dsh - 65'(dvr_q));
        quo_q <= {quo_q[62:0], 1'b1};
        amt_q <= {quo_q[62:0], 1'b1};
      end else begin
        drem_q <= dsh[63:0];
        quo_q <= {quo_q[62:0], 1'b0};
        amt_q <= {quo_q[62:0], 1'b0};
      end
      dcnt_q <= dcnt_q - 7'd1;
    end
    if (cmd_i.scale) begin
      speed_q <= mmv > 64'({SPEEDW{1'b1}}) ? {SPEEDW{1'b1}} : mmv[SPEEDW-1:0];
    end
    if (cmd_i.sat) speed_q <= {SPEEDW{1'b1}};
    if (cmd_i.pick) rate_q <= pk;
  end

  assign rate_o = rate_q;

endmodule

@@ hw/rtl/gesture_velocity_frame_rate_governor.sv @@
// gesture_velocity_frame_rate_governor: top level with config registers
// depends on gvfr_pkg, gvfr_ctrl, gvfr_dpath
//
// usage: one input word per gesture event on in_valid_i/in_ready_o, one
// result word per event on out_valid_o/out_ready_i. config writes via
// cfg_we_i, cfg_idx_i, cfg_data_i while idle.
// state ops answer in the cycle after acceptance. scroll updates take the
// root steps, one multiply, 64 divide steps, scale, lookup and output; with
// zero elapsed time the divide and scale give way to a saturated speed;
// fling updates skip multiply and divide. the divider and root are
// bit-serial. one event is in flight at a time.
// reset clears gesture state, current rate, config and last timestamp.
// a result waits in the output register while the receiver stalls; no new
// word is taken until it leaves.

module gesture_velocity_frame_rate_governor (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [2:0]           cfg_idx_i,
  input  logic [58:0]          cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [2:0]           op_i,
  input  logic signed [31:0]   motion_x_i,
  input  logic signed [31:0]   motion_y_i,
  input  logic [62:0]          timestamp_us_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic                 status_o,
  output logic [8:0]           frame_rate_o,
  output logic [1:0]           scene_notice_o
);

  logic [23:0] scale_q;
  logic [2:0]  mode_q;
  logic [58:0] scroll_q [3];
  logic [58:0] fling_q [3];
  gvfr_pkg::gvfr_cmd_t cmd;
  gvfr_pkg::gvfr_sts_t sts;
  logic [8:0] rate;
  logic clr_time, set_time;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q <= '0;
      mode_q <= '0;
      for (int i = 0; i < 3; i++) begin
        scroll_q[i] <= '0;
        fling_q[i] <= '0;
      end
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        gvfr_pkg::RegScale: scale_q <= cfg_data_i[23:0];
        gvfr_pkg::RegMode: mode_q <= cfg_data_i[2:0];
        gvfr_pkg::RegScroll0: scroll_q[0] <= cfg_data_i;
        gvfr_pkg::RegScroll1: scroll_q[1] <= cfg_data_i;
        gvfr_pkg::RegScroll2: scroll_q[2] <= cfg_data_i;
        gvfr_pkg::RegFling0: fling_q[0] <= cfg_data_i;
        gvfr_pkg::RegFling1: fling_q[1] <= cfg_data_i;
        gvfr_pkg::RegFling2: fling_q[2] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  gvfr_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .op_i, .mode_i(mode_q),
    .sts_i(sts), .rate_i(rate), .cmd_o(cmd), .clr_time_o(clr_time),
    .set_time_o(set_time), .out_valid_o, .out_ready_i, .status_o,
    .frame_rate_o, .scene_notice_o
  );

  gvfr_dpath u_dpath (
    .clk_i, .rst_ni, .cmd_i(cmd), .clr_time_i(clr_time), .set_time_i(set_time),
    .op_i, .motion_x_i, .motion_y_i, .timestamp_us_i, .scale_i(scale_q),
    .mode_i(mode_q), .scroll_i(scroll_q), .fling_i(fling_q), .sts_o(sts),
    .rate_o(rate)
  );

endmodule

@@ hw/rtl/gvfr_checker.sv @@
// gvfr_checker: port-level assertions for the governor
// depends on gesture_velocity_frame_rate_governor

module gvfr_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic       status_o,
  input logic [8:0] frame_rate_o,
  input logic [1:0] scene_notice_o
);

  a_no_ready_while_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o) else $error("ready with pending word");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(frame_rate_o))
    else $error("output word dropped");

  a_rate_zero_on_ignore: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o |-> frame_rate_o == 9'd0 && scene_notice_o == 2'd0)
    else $error("payload on ignored word");

endmodule

bind gesture_velocity_frame_rate_governor gvfr_checker u_chk (.*);

@@ tb/sv/tb.sv @@
`timescale 1ns / 100ps
// tb: self-checking bench for gesture_velocity_frame_rate_governor, with a
// scoreboard class that predicts each result word; depends on gvfr_pkg and the rtl

module tb;

  localparam logic [2:0] OpSpare6 = 3'd6;
  localparam logic [2:0] OpSpare7 = 3'd7;
  localparam logic [1:0] StratOff = 2'd0;
  localparam logic [1:0] StratRsvd = 2'd3;
  localparam int NumPhases = 10;
  localparam int WordsPerPhase = 145;

  class rate_board;
    logic [23:0] scale;
    logic [2:0]  mode;
    logic [58:0] scroll_tbl [3];
    logic [58:0] fling_tbl [3];
    bit          sliding;
    bit          flinging;
    logic [63:0] last_us;
    logic [8:0]  cur_rate;
    logic [11:0] pending [$];
    int          errors;

    function new();
      scale = '0;
      mode = '0;
      foreach (scroll_tbl[k]) begin
        scroll_tbl[k] = '0;
        fling_tbl[k] = '0;
      end
      stop_gesture();
      errors = 0;
    endfunction

    function void stop_gesture();
      sliding = 0;
      flinging = 0;
      last_us = '0;
      cur_rate = '0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [58:0] val);
      case (idx)
        gvfr_pkg::RegScale: scale = val[23:0];
        gvfr_pkg::RegMode: mode = val[2:0];
        gvfr_pkg::RegScroll0, gvfr_pkg::RegScroll1, gvfr_pkg::RegScroll2:
          scroll_tbl[idx - gvfr_pkg::RegScroll0] = val;
        default: fling_tbl[idx - gvfr_pkg::RegFling0] = val;
      endcase
    endfunction

    function logic [63:0] root(logic [63:0] v);
      logic [63:0] r;
      logic [63:0] b;
      r = '0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v = v - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
      return r;
    endfunction

    function logic [63:0] mm_per_s(logic [63:0] pps);
      logic [127:0] p;
      p = {64'd0, pps} * {104'd0, scale};
      p = p >> 28;
      return (p > 128'hFFFFFF) ? 64'hFFFFFF : p[63:0];
    endfunction

    function logic [8:0] lookup(logic [63:0] spd, bit use_fling);
      logic [58:0] e;
      logic [8:0]  r;
      r = gvfr_pkg::RateDefault;
      for (int k = 0; k < gvfr_pkg::EntriesPerTable; k++) begin
        e = use_fling ? fling_tbl[k] : scroll_tbl[k];
        if (e[0] && spd >= e[24:1] && (spd < e[48:25] || e[49])) begin
          r = e[58:50];
          break;
        end
      end
      if (mode[2] && r > gvfr_pkg::RateCap) r = gvfr_pkg::RateCap;
      return r;
    endfunction

    function void note_word(logic [2:0] op, logic [31:0] mx, logic [31:0] my,
                            logic [62:0] ts);
      bit          live;
      bit          aps;
      logic        st;
      logic [8:0]  rate;
      logic [1:0]  notice;
      logic [63:0] ax;
      logic [63:0] ay;
      logic [63:0] mag;
      logic [63:0] dt;
      logic [63:0] spd;
      logic [8:0]  r;
      live = (mode[1:0] == gvfr_pkg::StratTable) || (mode[1:0] == gvfr_pkg::StratAps);
      aps = (mode[1:0] == gvfr_pkg::StratAps);
      st = 1'b1;
      rate = '0;
      notice = gvfr_pkg::NoticeNone;
      case (op)
        gvfr_pkg::OpStartSlide: if (live && !sliding) begin
          last_us = {1'b0, ts};
          sliding = 1;
          flinging = 0;
          st = 1'b0;
        end
        gvfr_pkg::OpStopSlide: if (live && sliding && !flinging) begin
          stop_gesture();
          st = 1'b0;
        end
        gvfr_pkg::OpStartFling: if (live && sliding) begin
          if (aps) notice = gvfr_pkg::NoticeStart;
          flinging = 1;
          st = 1'b0;
        end
        gvfr_pkg::OpStopFling: if (live && sliding && flinging) begin
          if (aps) notice = gvfr_pkg::NoticeStop;
          stop_gesture();
          st = 1'b0;
        end
        gvfr_pkg::OpScroll, gvfr_pkg::OpFlingUpd: begin
          if (sliding && !aps &&
              ((op == gvfr_pkg::OpScroll) ? !flinging : flinging)) begin
            ax = {32'd0, mx[31] ? -mx : mx};
            ay = {32'd0, my[31] ? -my : my};
            mag = root(ax * ax + ay * ay);
            if (op == gvfr_pkg::OpScroll) begin
              dt = ({1'b0, ts} >= last_us) ? {1'b0, ts} - last_us : last_us - {1'b0, ts};
              last_us = {1'b0, ts};
              spd = (dt == 0) ? 64'hFFFFFF : mm_per_s((mag * 64'd1000000) / dt);
              r = lookup(spd, 0);
            end else begin
              r = lookup(mm_per_s(mag), 1);
            end
            if (r != cur_rate) begin
              cur_rate = r;
              rate = r;
              st = 1'b0;
            end
          end
        end
        default: ;
      endcase
      pending.push_back({st, rate, notice});
    endfunction

    function void check_word(logic st, logic [8:0] rate, logic [1:0] notice);
      logic [11:0] w;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result word status %0d rate %0d notice %0d",
                 $time, st, rate, notice);
        errors++;
        return;
      end
      w = pending.pop_front();
      if (st !== w[11]) begin
        $display("%0t: status expected %0d actual %0d", $time, w[11], st);
        errors++;
      end
      if (rate !== w[10:2]) begin
        $display("%0t: frame_rate expected %0d actual %0d", $time, w[10:2], rate);
        errors++;
      end
      if (notice !== w[1:0]) begin
        $display("%0t: scene_notice expected %0d actual %0d", $time, w[1:0], notice);
        errors++;
      end
    endfunction
  endclass

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [2:0]         cfg_idx_i;
  logic [58:0]        cfg_data_i;
  logic               in_valid_i;
  logic               in_ready_o;
  logic [2:0]         op_i;
  logic signed [31:0] motion_x_i;
  logic signed [31:0] motion_y_i;
  logic [62:0]        timestamp_us_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic               status_o;
  logic [8:0]         frame_rate_o;
  logic [1:0]         scene_notice_o;

  rate_board   board;
  bit          calm;
  bit          hold_req;
  int          sent;
  logic [62:0] t_now;

  gesture_velocity_frame_rate_governor dut (.*);

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #3000000;
    $display("CHECK FAILED");
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      board.check_word(status_o, frame_rate_o, scene_notice_o);
  end

  // result side: random stalls plus one long hold-off
  initial begin
    int gap;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_req) begin
        hold_req = 0;
        out_ready_i <= 1'b0;
        repeat (400) @(posedge clk_i);
      end
      gap = calm ? 0 : $urandom_range(0, 12);
      if (gap > 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
    end
  end

  task automatic send_word(logic [2:0] op, logic [31:0] mx, logic [31:0] my,
                           logic [62:0] ts);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    op_i <= op;
    motion_x_i <= mx;
    motion_y_i <= my;
    timestamp_us_i <= ts;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    board.note_word(op, mx, my, ts);
    sent++;
    if (sent == 600) hold_req = 1;
  endtask

  task automatic write_reg(logic [2:0] idx, logic [58:0] val);
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    board.write_reg(idx, val);
  endtask

  function automatic logic [58:0] rand_entry();
    logic [23:0] lo;
    logic [23:0] hi;
    if ($urandom_range(0, 7) == 0) return 59'({$urandom, $urandom});
    lo = 24'($urandom) >> $urandom_range(0, 24);
    hi = lo + (24'($urandom) >> $urandom_range(0, 24));
    return {9'($urandom), $urandom_range(0, 3) == 0, hi, lo, $urandom_range(0, 3) != 0};
  endfunction

  function automatic logic [31:0] rand_motion();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return 32'($signed($urandom_range(0, 8192)) - 4096);
      default: return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
    endcase
  endfunction

  function automatic logic [62:0] next_time();
    case ($urandom_range(0, 15))
      0: t_now = 63'({$urandom, $urandom});
      1: ;
      2: t_now = t_now - $urandom_range(1, 20000);
      default: t_now = t_now + $urandom_range(1, 50000);
    endcase
    return t_now;
  endfunction

  task automatic gesture();
    int n;
    if ($urandom_range(0, 9) == 0) begin
      send_word(3'($urandom_range(0, 7)), $urandom, $urandom, 63'({$urandom, $urandom}));
      return;
    end
    calm = ($urandom_range(0, 4) == 0);
    send_word(gvfr_pkg::OpStartSlide, rand_motion(), rand_motion(), next_time());
    n = $urandom_range(0, 6);
    repeat (n) send_word(gvfr_pkg::OpScroll, rand_motion(), rand_motion(), next_time());
    if ($urandom_range(0, 1)) begin
      send_word(gvfr_pkg::OpStartFling, rand_motion(), rand_motion(), next_time());
      n = $urandom_range(0, 5);
      repeat (n) send_word(gvfr_pkg::OpFlingUpd, rand_motion(), rand_motion(), next_time());
      send_word($urandom_range(0, 5) == 0 ? gvfr_pkg::OpStopSlide : gvfr_pkg::OpStopFling,
                rand_motion(), rand_motion(), next_time());
    end else begin
      send_word($urandom_range(0, 5) == 0 ? gvfr_pkg::OpStopFling : gvfr_pkg::OpStopSlide,
                rand_motion(), rand_motion(), next_time());
    end
  endtask

  initial begin
    logic [2:0] modes [NumPhases];
    logic [23:0] sc;
    board = new();
    calm = 0;
    hold_req = 0;
    sent = 0;
    t_now = '0;
    modes = '{{1'b0, gvfr_pkg::StratTable}, {1'b1, StratRsvd}, {1'b1, gvfr_pkg::StratTable},
              {1'b0, gvfr_pkg::StratAps}, {1'b0, StratOff}, {1'b1, gvfr_pkg::StratAps},
              {1'b0, gvfr_pkg::StratTable}, {1'b1, StratOff}, {1'b0, StratRsvd},
              {1'b1, gvfr_pkg::StratTable}};
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    op_i = gvfr_pkg::OpStartSlide;
    motion_x_i = '0;
    motion_y_i = '0;
    timestamp_us_i = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: extremes, every op, zero and backward time
    write_reg(gvfr_pkg::RegScale, 24'd104857);
    write_reg(gvfr_pkg::RegMode, {1'b0, gvfr_pkg::StratTable});
    write_reg(gvfr_pkg::RegScroll0, {9'd60, 1'b0, 24'd100, 24'd0, 1'b1});
    write_reg(gvfr_pkg::RegScroll1, {9'd500, 1'b1, 24'd0, 24'd100, 1'b1});
    write_reg(gvfr_pkg::RegFling0, {9'd511, 1'b1, 24'd0, 24'd0, 1'b1});
    send_word(gvfr_pkg::OpScroll, 32'd5, 32'd5, 63'd10);
    send_word(gvfr_pkg::OpStartSlide, '0, '0, 63'd1000);
    send_word(gvfr_pkg::OpStartSlide, '0, '0, 63'd2000);
    send_word(gvfr_pkg::OpScroll, 32'h80000000, 32'h80000000, 63'd1000);
    send_word(gvfr_pkg::OpScroll, 32'h7FFFFFFF, 32'h80000000, 63'd900);
    send_word(gvfr_pkg::OpScroll, 32'd1, 32'd0, {63{1'b1}});
    send_word(gvfr_pkg::OpScroll, 32'd1, 32'd0, 63'd0);
    send_word(gvfr_pkg::OpScroll, '0, '0, 63'd5000);
    send_word(gvfr_pkg::OpFlingUpd, 32'd256, 32'd256, 63'd0);
    send_word(gvfr_pkg::OpStopFling, '0, '0, 63'd0);
    send_word(gvfr_pkg::OpStartFling, '0, '0, 63'd0);
    send_word(gvfr_pkg::OpScroll, 32'd256, 32'd0, 63'd6000);
    send_word(gvfr_pkg::OpFlingUpd, 32'h80000000, 32'h7FFFFFFF, 63'd0);
    send_word(gvfr_pkg::OpFlingUpd, '0, '0, 63'd0);
    send_word(gvfr_pkg::OpStopSlide, '0, '0, 63'd0);
    send_word(OpSpare6, '1, '1, '1);
    send_word(OpSpare7, '0, '0, '0);
    send_word(gvfr_pkg::OpStopFling, '0, '0, 63'd0);
    send_word(gvfr_pkg::OpStopSlide, '0, '0, 63'd0);

    for (int ph = 0; ph < NumPhases; ph++) begin
      sc = (ph == 0) ? 24'd0 : (ph == 1) ? 24'hFFFFFF :
           ($urandom_range(0, 3) == 0) ? 24'($urandom) : 24'($urandom_range(20000, 400000));
      write_reg(gvfr_pkg::RegScale, sc);
      write_reg(gvfr_pkg::RegMode, modes[ph]);
      write_reg(gvfr_pkg::RegScroll0, rand_entry());
      write_reg(gvfr_pkg::RegScroll1, rand_entry());
      write_reg(gvfr_pkg::RegScroll2, rand_entry());
      write_reg(gvfr_pkg::RegFling0, rand_entry());
      write_reg(gvfr_pkg::RegFling1, rand_entry());
      write_reg(gvfr_pkg::RegFling2, rand_entry());
      while (sent < 20 + (ph + 1) * WordsPerPhase) gesture();
      calm = 0;
    end

    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (150) @(posedge clk_i);
    if (board.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hw/rtl/gvfr_pkg.sv
hw/rtl/gvfr_ctrl.sv
hw/rtl/gvfr_dpath.sv
hw/rtl/gesture_velocity_frame_rate_governor.sv
hw/rtl/gvfr_checker.sv
tb/sv/tb.sv
